/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the ALU block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion on the block's default clock and reset.
`define ASSERT_DFLT(name, prop, msg) `ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

/* hw/rtl/awfr_pkg.sv */
// ----------------------------------------------------------------------------
// awfr_pkg
// Opcodes, flag positions and controller/datapath interface types.
// ----------------------------------------------------------------------------
package awfr_pkg;

  localparam int unsigned OpW   = 6;
  localparam int unsigned DataW = 16;
  localparam int unsigned CntW  = 5;

  // Operation codes.
  localparam logic [OpW-1:0] OP_ADD_W  = 6'd0;
  localparam logic [OpW-1:0] OP_ADC_B  = 6'd1;
  localparam logic [OpW-1:0] OP_ADD_B  = 6'd2;
  localparam logic [OpW-1:0] OP_ADD_WB = 6'd3;
  localparam logic [OpW-1:0] OP_SUB_B  = 6'd4;
  localparam logic [OpW-1:0] OP_SUB_W  = 6'd5;
  localparam logic [OpW-1:0] OP_SBB_W  = 6'd6;
  localparam logic [OpW-1:0] OP_SBB_B  = 6'd7;
  localparam logic [OpW-1:0] OP_CLD    = 6'd8;
  localparam logic [OpW-1:0] OP_STD    = 6'd9;
  localparam logic [OpW-1:0] OP_CLI    = 6'd10;
  localparam logic [OpW-1:0] OP_STI    = 6'd11;
  localparam logic [OpW-1:0] OP_STC    = 6'd12;
  localparam logic [OpW-1:0] OP_CLC    = 6'd13;
  localparam logic [OpW-1:0] OP_CMC    = 6'd14;
  localparam logic [OpW-1:0] OP_XOR_B  = 6'd15;
  localparam logic [OpW-1:0] OP_OR_B   = 6'd16;
  localparam logic [OpW-1:0] OP_OR_W   = 6'd17;
  localparam logic [OpW-1:0] OP_AND_B  = 6'd18;
  localparam logic [OpW-1:0] OP_TEST_B = 6'd19;
  localparam logic [OpW-1:0] OP_CMP_B  = 6'd20;
  localparam logic [OpW-1:0] OP_CMP_W  = 6'd21;
  localparam logic [OpW-1:0] OP_INC_W  = 6'd22;
  localparam logic [OpW-1:0] OP_INC_B  = 6'd23;
  localparam logic [OpW-1:0] OP_DEC_B  = 6'd24;
  localparam logic [OpW-1:0] OP_DEC_W  = 6'd25;
  localparam logic [OpW-1:0] OP_SHL_W  = 6'd26;
  localparam logic [OpW-1:0] OP_SHL_B  = 6'd27;
  localparam logic [OpW-1:0] OP_SHR_B  = 6'd28;
  localparam logic [OpW-1:0] OP_MUL_W  = 6'd29;
  localparam logic [OpW-1:0] OP_MUL_B  = 6'd30;
  localparam logic [OpW-1:0] OP_RCL_W  = 6'd31;
  localparam logic [OpW-1:0] OP_RCL_B  = 6'd32;
  localparam logic [OpW-1:0] OP_RCR_B  = 6'd33;

  // Flag bit positions in the 8086 flags word.
  localparam int unsigned FLAG_CF = 0;
  localparam int unsigned FLAG_PF = 2;
  localparam int unsigned FLAG_ZF = 6;
  localparam int unsigned FLAG_SF = 7;
  localparam int unsigned FLAG_IF = 9;
  localparam int unsigned FLAG_DF = 10;
  localparam int unsigned FLAG_OF = 11;

  // Bits of the flags word that no operation ever writes.
  localparam logic [DataW-1:0] FLAGS_UNUSED_MASK = 16'hF13A;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input beat
    logic exec;      // evaluate the operation or set up the rotate
    logic rot_step;  // one rotate-through-carry step
    logic rot_fin;   // commit the rotate result and flags
    logic out_load;  // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_rot;    // the captured opcode is a rotate through carry
    logic rot_zero;  // no rotate steps remain
  } sts_t;

endpackage

/* hw/rtl/awfr_dp.sv */
// ----------------------------------------------------------------------------
// awfr_dp
// ALU datapath: operand capture, single-cycle operations, rotate unit,
// flags register and output register.
// ----------------------------------------------------------------------------
module awfr_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  awfr_pkg::cmd_t                      cmd_i,
  output awfr_pkg::sts_t                      sts_o,
  input  logic [awfr_pkg::OpW-1:0]            opcode_i,
  input  logic [awfr_pkg::DataW-1:0]          operand_a_i,
  input  logic [awfr_pkg::DataW-1:0]          operand_b_i,
  output logic [awfr_pkg::DataW-1:0]          result_low_o,
  output logic [awfr_pkg::DataW-1:0]          result_high_o,
  output logic                                write_back_o,
  output logic [awfr_pkg::DataW-1:0]          flags_out_o
);
  import awfr_pkg::*;

  // Reciprocal constants for the count reduction modulo 17 and modulo 9.
  localparam logic [15:0] Recip17 = 16'd241;
  localparam logic [13:0] Recip9  = 14'd57;

  logic [OpW-1:0]   op_q;
  logic [DataW-1:0] a_q, b_q;
  logic [DataW-1:0] flags_q;
  logic [DataW-1:0] res_lo_q, res_hi_q;
  logic             res_wb_q;
  logic [DataW-1:0] rot_t_q;
  logic             rot_c_q;
  logic [CntW-1:0]  rot_n_q;
  logic             rcr_of_q;
  logic [DataW-1:0] out_lo_q, out_hi_q, out_flags_q;
  logic             out_wb_q;

  logic [7:0]  a8, b8;
  logic        cf_in;
  logic [16:0] add_w, add_wb, sub_w, sbb_w;
  logic [8:0]  add_b, adc_b, sub_b, sbb_b;
  logic [31:0] mul_w;
  logic [15:0] mul_b;
  logic [15:0] shl_w;
  logic [7:0]  shl_b, shr_b;
  logic        is_rot;
  logic [15:0] q17_prod;
  logic [7:0]  m17, n17;
  logic [13:0] q9_prod;
  logic [7:0]  m9, n9;
  logic [DataW-1:0] ex_lo, ex_hi, ex_flags, fin_flags;
  logic             ex_wb, zsp_upd, zsp_word;

  assign a8    = a_q[7:0];
  assign b8    = b_q[7:0];
  assign cf_in = flags_q[FLAG_CF];

  // Adders, subtractors, multipliers and shifters.
  assign add_w  = {1'b0, a_q} + {1'b0, b_q};
  assign add_wb = {1'b0, a_q} + {9'b0, b8};
  assign add_b  = {1'b0, a8} + {1'b0, b8};
  assign adc_b  = add_b + {8'b0, cf_in};
  assign sub_w  = {1'b0, a_q} - {1'b0, b_q};
  assign sbb_w  = sub_w - {16'b0, cf_in};
  assign sub_b  = {1'b0, a8} - {1'b0, b8};
  assign sbb_b  = sub_b - {8'b0, cf_in};
  assign mul_w  = {16'b0, a_q} * {16'b0, b_q};
  assign mul_b  = {8'b0, a8} * {8'b0, b8};
  assign shl_w  = (b8 >= 8'd16) ? '0 : (a_q << b8[3:0]);
  assign shl_b  = (b8 >= 8'd8) ? '0 : (a8 << b8[2:0]);
  assign shr_b  = (b8 >= 8'd8) ? '0 : (a8 >> b8[2:0]);

  assign is_rot = (op_q == OP_RCL_W) || (op_q == OP_RCL_B) || (op_q == OP_RCR_B);

  // Rotate count reduced modulo 17 (word) or 9 (byte) by reciprocal multiply.
  assign q17_prod = {8'b0, b8} * Recip17;
  assign m17      = {4'b0, q17_prod[15:12]} * 8'd17;
  assign n17      = b8 - m17;
  assign q9_prod  = {6'b0, b8} * Recip9;
  assign m9       = {3'b0, q9_prod[13:9]} * 8'd9;
  assign n9       = b8 - m9;

  // Result and flags of the single-cycle operations.
  always_comb begin
    ex_lo    = '0;
    ex_hi    = '0;
    ex_wb    = 1'b1;
    ex_flags = flags_q;
    zsp_upd  = 1'b0;
    zsp_word = 1'b0;
    unique case (op_q) inside
      OP_ADD_W: begin
        ex_lo = add_w[15:0]; ex_flags[FLAG_CF] = add_w[16];
        zsp_upd = 1'b1; zsp_word = 1'b1;
      end
      OP_ADC_B: begin
        ex_lo = {8'b0, adc_b[7:0]}; ex_flags[FLAG_CF] = adc_b[8];
        zsp_upd = 1'b1;
      end
      OP_ADD_B: begin
        ex_lo = {8'b0, add_b[7:0]}; ex_flags[FLAG_CF] = add_b[8];
        zsp_upd = 1'b1;
      end
      OP_ADD_WB: begin
        ex_lo = add_wb[15:0]; ex_flags[FLAG_CF] = add_wb[16];
        zsp_upd = 1'b1; zsp_word = 1'b1;
      end
      OP_SUB_B, OP_CMP_B: begin
        ex_lo = {8'b0, sub_b[7:0]}; ex_flags[FLAG_CF] = sub_b[8];
        zsp_upd = 1'b1; ex_wb = (op_q == OP_SUB_B);
      end
      OP_SUB_W, OP_CMP_W: begin
        ex_lo = sub_w[15:0]; ex_flags[FLAG_CF] = sub_w[16];
        zsp_upd = 1'b1; zsp_word = 1'b1; ex_wb = (op_q == OP_SUB_W);
      end
      OP_SBB_W: begin
        ex_lo = sbb_w[15:0]; ex_flags[FLAG_CF] = sbb_w[16];
        zsp_upd = 1'b1; zsp_word = 1'b1;
      end
      OP_SBB_B: begin
        ex_lo = {8'b0, sbb_b[7:0]}; ex_flags[FLAG_CF] = sbb_b[8];
        zsp_upd = 1'b1;
      end
      OP_CLD: begin ex_flags[FLAG_DF] = 1'b0; ex_wb = 1'b0; end
      OP_STD: begin ex_flags[FLAG_DF] = 1'b1; ex_wb = 1'b0; end
      OP_CLI: begin ex_flags[FLAG_IF] = 1'b0; ex_wb = 1'b0; end
      OP_STI: begin ex_flags[FLAG_IF] = 1'b1; ex_wb = 1'b0; end
      OP_STC: begin ex_flags[FLAG_CF] = 1'b1; ex_wb = 1'b0; end
      OP_CLC: begin ex_flags[FLAG_CF] = 1'b0; ex_wb = 1'b0; end
      OP_CMC: begin ex_flags[FLAG_CF] = ~cf_in; ex_wb = 1'b0; end
      OP_XOR_B, OP_OR_B, OP_AND_B, OP_TEST_B: begin
        if (op_q == OP_XOR_B) begin
          ex_lo = {8'b0, a8 ^ b8};
        end else if (op_q == OP_OR_B) begin
          ex_lo = {8'b0, a8 | b8};
        end else begin
          ex_lo = {8'b0, a8 & b8};
        end
        ex_flags[FLAG_CF] = 1'b0; ex_flags[FLAG_OF] = 1'b0;
        zsp_upd = 1'b1; ex_wb = (op_q != OP_TEST_B);
      end
      OP_OR_W: begin
        ex_lo = a_q | b_q;
        ex_flags[FLAG_CF] = 1'b0; ex_flags[FLAG_OF] = 1'b0;
        zsp_upd = 1'b1; zsp_word = 1'b1;
      end
      OP_INC_W: begin ex_lo = a_q + 16'd1; zsp_upd = 1'b1; zsp_word = 1'b1; end
      OP_INC_B: begin ex_lo = {8'b0, a8 + 8'd1}; zsp_upd = 1'b1; end
      OP_DEC_B: begin ex_lo = {8'b0, a8 - 8'd1}; zsp_upd = 1'b1; end
      OP_DEC_W: begin ex_lo = a_q - 16'd1; zsp_upd = 1'b1; zsp_word = 1'b1; end
      OP_SHL_W: begin ex_lo = shl_w; zsp_upd = 1'b1; zsp_word = 1'b1; end
      OP_SHL_B: begin ex_lo = {8'b0, shl_b}; zsp_upd = 1'b1; end
      OP_SHR_B: begin ex_lo = {8'b0, shr_b}; zsp_upd = 1'b1; end
      OP_MUL_W: begin
        ex_lo = mul_w[15:0]; ex_hi = mul_w[31:16];
        ex_flags[FLAG_CF] = (mul_w[31:16] != '0);
        ex_flags[FLAG_OF] = (mul_w[31:16] != '0);
      end
      OP_MUL_B: begin
        ex_lo = mul_b;
        ex_flags[FLAG_CF] = (mul_b[15:8] != '0);
        ex_flags[FLAG_OF] = (mul_b[15:8] != '0);
      end
      default: begin
        // Undefined codes and rotates: rotates are committed later.
        ex_wb = 1'b0;
      end
    endcase
    // Zero, sign and parity from the low result.
    if (zsp_upd) begin
      ex_flags[FLAG_ZF] = zsp_word ? (ex_lo == '0) : (ex_lo[7:0] == '0);
      ex_flags[FLAG_SF] = zsp_word ? ex_lo[15] : ex_lo[7];
      ex_flags[FLAG_PF] = ~^ex_lo[7:0];
    end
  end

  // Flags at the end of a rotate.
  always_comb begin
    fin_flags = flags_q;
    fin_flags[FLAG_CF] = rot_c_q;
    if (b8 == 8'd1) begin
      if (op_q == OP_RCR_B) begin
        fin_flags[FLAG_OF] = rcr_of_q;
      end else if (op_q == OP_RCL_W) begin
        fin_flags[FLAG_OF] = rot_t_q[15] ^ rot_c_q;
      end else begin
        fin_flags[FLAG_OF] = rot_t_q[7] ^ rot_c_q;
      end
    end
  end

  // Flags register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (cmd_i.exec && !is_rot) begin
      flags_q <= ex_flags;
    end else if (cmd_i.rot_fin) begin
      flags_q <= fin_flags;
    end
  end

  // Operand capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= opcode_i;
      a_q  <= operand_a_i;
      b_q  <= operand_b_i;
    end
  end

  // Rotate-through-carry unit: set up, then one bit each step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rot_t_q  <= (op_q == OP_RCL_W) ? a_q : {8'b0, a8};
      rot_c_q  <= cf_in;
      rot_n_q  <= (op_q == OP_RCL_W) ? n17[CntW-1:0] : n9[CntW-1:0];
      rcr_of_q <= a8[7] ^ cf_in;
    end else if (cmd_i.rot_step) begin
      rot_n_q <= rot_n_q - CntW'(1);
      if (op_q == OP_RCL_W) begin
        rot_t_q <= {rot_t_q[14:0], rot_c_q};
        rot_c_q <= rot_t_q[15];
      end else if (op_q == OP_RCL_B) begin
        rot_t_q <= {8'b0, rot_t_q[6:0], rot_c_q};
        rot_c_q <= rot_t_q[7];
      end else begin
        rot_t_q <= {8'b0, rot_c_q, rot_t_q[7:1]};
        rot_c_q <= rot_t_q[0];
      end
    end
  end

  // Finished result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && !is_rot) begin
      res_lo_q <= ex_lo;
      res_hi_q <= ex_hi;
      res_wb_q <= ex_wb;
    end else if (cmd_i.rot_fin) begin
      res_lo_q <= rot_t_q;
      res_hi_q <= '0;
      res_wb_q <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_lo_q    <= res_lo_q;
      out_hi_q    <= res_hi_q;
      out_wb_q    <= res_wb_q;
      out_flags_q <= flags_q;
    end
  end

  assign sts_o.is_rot   = is_rot;
  assign sts_o.rot_zero = (rot_n_q == '0);

  assign result_low_o  = out_lo_q;
  assign result_high_o = out_hi_q;
  assign write_back_o  = out_wb_q;
  assign flags_out_o   = out_flags_q;

endmodule

/* hw/rtl/awfr_ctrl.sv */
// ----------------------------------------------------------------------------
// awfr_ctrl
// Controller: sequences capture, execute, rotate steps and result hand-off,
// and owns the input stall and output valid.
// ----------------------------------------------------------------------------
module awfr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  awfr_pkg::sts_t sts_i,
  output awfr_pkg::cmd_t cmd_o
);
  import awfr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_ROT  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  // The output register can take a new beat when empty or being drained.
  assign slot_free = !out_valid_q || !out_stall_i;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.is_rot ? S_ROT : S_DONE;
      end
      S_ROT: begin
        if (sts_i.rot_zero) begin
          cmd_o.rot_fin = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.rot_step = 1'b1;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid: set on hand-off, cleared when the beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/alu_with_flags_register_top.sv */
// An accepted beat passes through execute and then hand-off to the output register;
// rotates add n steps of the one-bit-per-cycle rotate-through-carry unit, where n is
// the count reduced modulo 17 (word) or 9 (byte), up to 16. Hand-off waits while the
// output is full and stalled; a new beat is accepted only once the block is idle again.
// Reset clears the flags word, the controller state and the output valid.
// ----------------------------------------------------------------------------
// alu_with_flags_register_top
// 8086-subset ALU with a stored flags word, valid/stall on both channels.
// ----------------------------------------------------------------------------
module alu_with_flags_register_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [awfr_pkg::OpW-1:0]   opcode_i,
  input  logic [awfr_pkg::DataW-1:0] operand_a_i,
  input  logic [awfr_pkg::DataW-1:0] operand_b_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [awfr_pkg::DataW-1:0] result_low_o,
  output logic [awfr_pkg::DataW-1:0] result_high_o,
  output logic                       write_back_o,
  output logic [awfr_pkg::DataW-1:0] flags_out_o
);
  import awfr_pkg::*;

  `include "assert_macros.svh"

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  awfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath.
  awfr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (opcode_i),
    .operand_a_i   (operand_a_i),
    .operand_b_i   (operand_b_i),
    .result_low_o  (result_low_o),
    .result_high_o (result_high_o),
    .write_back_o  (write_back_o),
    .flags_out_o   (flags_out_o)
  );

  // An accepted beat keeps the block busy on the next cycle.
  `ASSERT_DFLT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "not busy after accept")

  // A new result appears only as the block returns to idle.
  `ASSERT_DFLT(a_idle_on_result, $rose(out_valid_o) |-> !in_stall_o, "result without idle")

  // Flag bits that no operation writes stay clear.
  `ASSERT_DFLT(a_unused_flags, out_valid_o |-> ((flags_out_o & FLAGS_UNUSED_MASK) == '0), "unused flag set")

endmodule
